// ===== hw/rtl/ltl_pkg.sv =====
`default_nettype none

package ltl_pkg;

    // one raw input byte with its side flags
    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_file;
        logic       sym_digits;
    } item_t;

    typedef enum logic [4:0] {
        TOK_END    = 5'd0,
        TOK_NL     = 5'd1,
        TOK_COLON  = 5'd2,
        TOK_SEMI   = 5'd3,
        TOK_COMMA  = 5'd4,
        TOK_PLUS   = 5'd5,
        TOK_MINUS  = 5'd6,
        TOK_MULT   = 5'd7,
        TOK_DIV    = 5'd8,
        TOK_LPAREN = 5'd9,
        TOK_RPAREN = 5'd10,
        TOK_LBRACE = 5'd11,
        TOK_RBRACE = 5'd12,
        TOK_SYMBOL = 5'd13,
        TOK_INT    = 5'd14,
        TOK_FLOAT  = 5'd15,
        TOK_ERROR  = 5'd16
    } token_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_ILLEGAL  = 3'd1,
        ERR_NO_DIGIT = 3'd2,
        ERR_NO_EXP   = 3'd3,
        ERR_NL_STR   = 3'd4,
        ERR_EOF_STR  = 3'd5,
        ERR_EOF_CMT  = 3'd6
    } err_t;

    // one result transaction
    typedef struct packed {
        logic        is_token;
        logic [7:0]  text_char;
        logic [4:0]  token_type;
        logic [2:0]  error_kind;
        logic [15:0] line_number;
        logic [15:0] first_column;
        logic [15:0] last_column;
        logic        last;
    } result_t;

    // everything one byte produces: up to two results
    typedef struct packed {
        logic [1:0]       count;
        result_t [1:0]    res;
    } step_out_t;

    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = 2;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_A_UP   = 8'h41;
    localparam logic [7:0] CH_E_UP   = 8'h45;
    localparam logic [7:0] CH_Z_UP   = 8'h5A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_A_LO   = 8'h61;
    localparam logic [7:0] CH_E_LO   = 8'h65;
    localparam logic [7:0] CH_Z_LO   = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

endpackage

`default_nettype wire

// ===== hw/rtl/ltl_in_if.sv =====
`default_nettype none

interface ltl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_file;
    logic       sym_digits;

    modport source (output valid, output char_in, output end_of_file, output sym_digits,
                    input ready);
    modport sink (input valid, input char_in, input end_of_file, input sym_digits,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ltl_out_if.sv =====
`default_nettype none

interface ltl_out_if;
    logic        valid;
    logic        ready;
    logic        is_token;
    logic [7:0]  text_char;
    logic [4:0]  token_type;
    logic [2:0]  error_kind;
    logic [15:0] line_number;
    logic [15:0] first_column;
    logic [15:0] last_column;
    logic        last;

    modport source (output valid, output is_token, output text_char, output token_type,
                    output error_kind, output line_number, output first_column,
                    output last_column, output last, input ready);
    modport sink (input valid, input is_token, input text_char, input token_type,
                  input error_kind, input line_number, input first_column,
                  input last_column, input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/liberty_text_lexer.sv =====
// flow: a byte transaction is registered in the input stage; its results are written to the
// result queue and leave from its head, a second result of the same byte after the first
// throughput: one byte per cycle while each byte makes at most one result and the receiver
// is ready; the single read port of the four-entry queue gives one result per cycle at most
// reset: rst_n asynchronous, clears lexer state, queue and positions, line counter to one
`default_nettype none

module liberty_text_lexer #(
    parameter int POSITION_BITS = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ltl_in_if.sink     char_stream,
    ltl_out_if.source  lex_stream
);

    // input register stage
    ltl_pkg::item_t     item_reg;
    logic               item_valid_reg, item_valid_next;
    logic               in_take;

    // one lexing step per cycle when the queue has room for two results
    logic               step_fire;
    ltl_pkg::step_out_t step_out;

    // result queue side
    ltl_pkg::result_t   head;
    logic               q_not_empty;
    logic               q_room;
    logic               q_pop;

    assign step_fire         = item_valid_reg && q_room;
    assign char_stream.ready = !item_valid_reg || step_fire;
    assign in_take           = char_stream.valid && char_stream.ready;
    assign item_valid_next   = in_take || (item_valid_reg && !step_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.char_in     <= char_stream.char_in;
            item_reg.end_of_file <= char_stream.end_of_file;
            item_reg.sym_digits  <= char_stream.sym_digits;
        end
    end

    // lexer: newline folding, position counters and the token state machine
    ltl_lex_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_valid (step_fire),
        .item       (item_reg),
        .step_out   (step_out)
    );

    // results of a step enter the queue together and leave one transaction at a time
    ltl_res_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (step_fire),
        .push      (step_out),
        .pop       (q_pop),
        .head      (head),
        .not_empty (q_not_empty),
        .room      (q_room)
    );

    assign q_pop = lex_stream.valid && lex_stream.ready;

    // output channel straight from the queue head
    assign lex_stream.valid        = q_not_empty;
    assign lex_stream.is_token     = head.is_token;
    assign lex_stream.text_char    = head.text_char;
    assign lex_stream.token_type   = head.token_type;
    assign lex_stream.error_kind   = head.error_kind;
    assign lex_stream.line_number  = head.line_number;
    assign lex_stream.first_column = head.first_column;
    assign lex_stream.last_column  = head.last_column;
    assign lex_stream.last         = head.last;

endmodule

`default_nettype wire

// ===== hw/rtl/ltl_lex_core.sv =====
`default_nettype none

module ltl_lex_core #(
    parameter int POSITION_BITS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step_valid,
    input  wire ltl_pkg::item_t    item,
    output ltl_pkg::step_out_t     step_out
);

    typedef enum logic [14:0] {
        S_IDLE    = 15'h0001,
        S_IDLE_BS = 15'h0002,
        S_MINUS   = 15'h0004,
        S_NUM1    = 15'h0008,
        S_DOT     = 15'h0010,
        S_NUM2    = 15'h0020,
        S_NUM3    = 15'h0040,
        S_NUM4    = 15'h0080,
        S_ID      = 15'h0100,
        S_DQ      = 15'h0200,
        S_DQ_BS   = 15'h0400,
        S_CMT1    = 15'h0800,
        S_CMT2    = 15'h1000,
        S_CMT3    = 15'h2000,
        S_CMT4    = 15'h4000
    } lex_state_t;

    lex_state_t               state_reg, state_next;
    logic                     cr_reg, cr_next;
    logic                     pnl_reg, pnl_next;
    logic [POSITION_BITS-1:0] line_reg, line_next;
    logic [POSITION_BITS-1:0] col_reg, col_next;
    logic [POSITION_BITS-1:0] first_reg, first_next;
    logic [POSITION_BITS-1:0] last_reg, last_next;

    lex_state_t               st_v;
    logic [POSITION_BITS-1:0] fc_v, lc_v;
    logic [7:0]               c_v;
    logic                     eof_v, drop_v, go_v;
    logic                     dig_v, alpha_v, symch_v;
    logic                     take_v, tok_v, minus_v;
    ltl_pkg::token_t          tok_type_v;
    ltl_pkg::err_t            tok_err_v;
    logic [1:0]               n_v;
    ltl_pkg::result_t         res_v [2];

    function automatic ltl_pkg::result_t mk_text(
        input logic [7:0]               ch,
        input logic [POSITION_BITS-1:0] ln,
        input logic [POSITION_BITS-1:0] fcol,
        input logic [POSITION_BITS-1:0] lcol
    );
        ltl_pkg::result_t r;
        r              = '0;
        r.text_char    = ch;
        r.line_number  = 16'(ln);
        r.first_column = 16'(fcol);
        r.last_column  = 16'(lcol);
        return r;
    endfunction

    function automatic ltl_pkg::result_t mk_tok(
        input ltl_pkg::token_t          typ,
        input ltl_pkg::err_t            err,
        input logic [POSITION_BITS-1:0] ln,
        input logic [POSITION_BITS-1:0] fcol,
        input logic [POSITION_BITS-1:0] lcol
    );
        ltl_pkg::result_t r;
        r              = '0;
        r.is_token     = 1'b1;
        r.token_type   = typ;
        r.error_kind   = err;
        r.line_number  = 16'(ln);
        r.first_column = 16'(fcol);
        r.last_column  = 16'(lcol);
        return r;
    endfunction

    always_comb
    begin
        cr_next    = cr_reg;
        pnl_next   = pnl_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        st_v       = state_reg;
        fc_v       = first_reg;
        lc_v       = last_reg;
        n_v        = '0;
        res_v[0]   = '0;
        res_v[1]   = '0;
        go_v       = 1'b0;
        take_v     = 1'b0;
        tok_v      = 1'b0;
        minus_v    = 1'b0;
        tok_type_v = ltl_pkg::TOK_END;
        tok_err_v  = ltl_pkg::ERR_NONE;
        drop_v     = 1'b0;
        eof_v      = item.end_of_file;
        c_v        = eof_v ? 8'h00 : item.char_in;

        // newline folding: CR becomes LF, LF right after CR vanishes
        if (!eof_v)
        begin
            if (c_v == ltl_pkg::CH_CR)
            begin
                cr_next = 1'b1;
                c_v     = ltl_pkg::CH_LF;
            end
            else if (c_v == ltl_pkg::CH_LF)
            begin
                if (cr_reg)
                begin
                    cr_next = 1'b0;
                    drop_v  = 1'b1;
                end
            end
            else
            begin
                cr_next = 1'b0;
            end
        end

        dig_v   = !eof_v && (c_v >= ltl_pkg::CH_0) && (c_v <= ltl_pkg::CH_9);
        alpha_v = !eof_v && (((c_v >= ltl_pkg::CH_A_LO) && (c_v <= ltl_pkg::CH_Z_LO)) ||
                             ((c_v >= ltl_pkg::CH_A_UP) && (c_v <= ltl_pkg::CH_Z_UP)));
        symch_v = alpha_v || (!eof_v && (c_v == ltl_pkg::CH_UNDER)) ||
                  (item.sym_digits && (dig_v || (!eof_v && (c_v == ltl_pkg::CH_DOT))));

        if (!drop_v)
        begin
            // saturating position counters
            if (pnl_reg)
            begin
                if (!(&line_reg))
                begin
                    line_next = line_reg + 1'b1;
                end
                col_next = POSITION_BITS'(1);
            end
            else if (!(&col_reg))
            begin
                col_next = col_reg + 1'b1;
            end
            pnl_next = !eof_v && (c_v == ltl_pkg::CH_LF);
            go_v     = 1'b1;
        end

        // second pass re-runs the ending byte from idle
        for (int p = 0; p < 2; p++)
        begin
            if (go_v)
            begin
                go_v       = 1'b0;
                take_v     = 1'b0;
                tok_v      = 1'b0;
                minus_v    = 1'b0;
                tok_type_v = ltl_pkg::TOK_END;
                tok_err_v  = ltl_pkg::ERR_NONE;
                unique case (st_v)
                    S_IDLE:
                    begin
                        fc_v = col_next;
                        if (eof_v)
                        begin
                            tok_v = 1'b1;
                            tok_type_v = ltl_pkg::TOK_END;
                        end
                        else if (symch_v)
                        begin
                            take_v = 1'b1;
                            st_v   = S_ID;
                        end
                        else if (dig_v)
                        begin
                            take_v = 1'b1;
                            st_v   = S_NUM1;
                        end
                        else
                        begin
                            unique case (c_v) inside
                                ltl_pkg::CH_DOT:
                                begin
                                    take_v = 1'b1;
                                    st_v   = S_DOT;
                                end
                                ltl_pkg::CH_SPACE, ltl_pkg::CH_TAB: ;
                                ltl_pkg::CH_LF:
                                begin
                                    tok_v = 1'b1;
                                    tok_type_v = ltl_pkg::TOK_NL;
                                end
                                ltl_pkg::CH_DQUOTE: st_v = S_DQ;
                                ltl_pkg::CH_BSLASH: st_v = S_IDLE_BS;
                                ltl_pkg::CH_SLASH:  st_v = S_CMT1;
                                ltl_pkg::CH_MINUS:  st_v = S_MINUS;
                                ltl_pkg::CH_COLON:
                                begin
                                    tok_v = 1'b1;
                                    tok_type_v = ltl_pkg::TOK_COLON;
                                end
                                ltl_pkg::CH_SEMI:
                                begin
                                    tok_v = 1'b1;
                                    tok_type_v = ltl_pkg::TOK_SEMI;
                                end
                                ltl_pkg::CH_COMMA:
                                begin
                                    tok_v = 1'b1;
                                    tok_type_v = ltl_pkg::TOK_COMMA;
                                end
                                ltl_pkg::CH_PLUS:
                                begin
                                    tok_v = 1'b1;
                                    tok_type_v = ltl_pkg::TOK_PLUS;
                                end
                                ltl_pkg::CH_STAR:
                                begin
                                    tok_v = 1'b1;
                                    tok_type_v = ltl_pkg::TOK_MULT;
                                end
                                ltl_pkg::CH_LPAREN:
                                begin
                                    tok_v = 1'b1;
                                    tok_type_v = ltl_pkg::TOK_LPAREN;
                                end
                                ltl_pkg::CH_RPAREN:
                                begin
                                    tok_v = 1'b1;
                                    tok_type_v = ltl_pkg::TOK_RPAREN;
                                end
                                ltl_pkg::CH_LBRACE:
                                begin
                                    tok_v = 1'b1;
                                    tok_type_v = ltl_pkg::TOK_LBRACE;
                                end
                                ltl_pkg::CH_RBRACE:
                                begin
                                    tok_v = 1'b1;
                                    tok_type_v = ltl_pkg::TOK_RBRACE;
                                end
                                default:
                                begin
                                    tok_v      = 1'b1;
                                    tok_type_v = ltl_pkg::TOK_ERROR;
                                    tok_err_v  = ltl_pkg::ERR_ILLEGAL;
                                end
                            endcase
                        end
                    end
                    S_IDLE_BS:
                    begin
                        st_v = S_IDLE;
                        go_v = eof_v || (c_v != ltl_pkg::CH_LF);
                    end
                    S_MINUS:
                    begin
                        if (dig_v)
                        begin
                            minus_v = 1'b1;
                            take_v  = 1'b1;
                            st_v    = S_NUM1;
                        end
                        else
                        begin
                            tok_v      = 1'b1;
                            tok_type_v = ltl_pkg::TOK_MINUS;
                            st_v       = S_IDLE;
                            go_v       = 1'b1;
                        end
                    end
                    S_NUM1:
                    begin
                        if (dig_v)
                        begin
                            take_v = 1'b1;
                        end
                        else if (c_v == ltl_pkg::CH_DOT && !eof_v)
                        begin
                            take_v = 1'b1;
                            st_v   = S_DOT;
                        end
                        else
                        begin
                            tok_v      = 1'b1;
                            tok_type_v = ltl_pkg::TOK_INT;
                            st_v       = S_IDLE;
                            go_v       = 1'b1;
                        end
                    end
                    S_DOT:
                    begin
                        if (dig_v)
                        begin
                            take_v = 1'b1;
                            st_v   = S_NUM2;
                        end
                        else
                        begin
                            tok_v      = 1'b1;
                            tok_type_v = ltl_pkg::TOK_ERROR;
                            tok_err_v  = ltl_pkg::ERR_NO_DIGIT;
                            st_v       = S_IDLE;
                        end
                    end
                    S_NUM2:
                    begin
                        if (dig_v)
                        begin
                            take_v = 1'b1;
                        end
                        else if (!eof_v && (c_v == ltl_pkg::CH_E_LO || c_v == ltl_pkg::CH_E_UP))
                        begin
                            take_v = 1'b1;
                            st_v   = S_NUM3;
                        end
                        else
                        begin
                            tok_v      = 1'b1;
                            tok_type_v = ltl_pkg::TOK_FLOAT;
                            st_v       = S_IDLE;
                            go_v       = 1'b1;
                        end
                    end
                    S_NUM3:
                    begin
                        if (dig_v || (!eof_v &&
                            (c_v == ltl_pkg::CH_PLUS || c_v == ltl_pkg::CH_MINUS)))
                        begin
                            take_v = 1'b1;
                            st_v   = S_NUM4;
                        end
                        else
                        begin
                            tok_v      = 1'b1;
                            tok_type_v = ltl_pkg::TOK_ERROR;
                            tok_err_v  = ltl_pkg::ERR_NO_EXP;
                            st_v       = S_IDLE;
                        end
                    end
                    S_NUM4:
                    begin
                        if (dig_v)
                        begin
                            take_v = 1'b1;
                        end
                        else
                        begin
                            tok_v      = 1'b1;
                            tok_type_v = ltl_pkg::TOK_FLOAT;
                            st_v       = S_IDLE;
                            go_v       = 1'b1;
                        end
                    end
                    S_ID:
                    begin
                        if (symch_v || dig_v)
                        begin
                            take_v = 1'b1;
                        end
                        else
                        begin
                            tok_v      = 1'b1;
                            tok_type_v = ltl_pkg::TOK_SYMBOL;
                            st_v       = S_IDLE;
                            go_v       = 1'b1;
                        end
                    end
                    S_DQ:
                    begin
                        if (eof_v)
                        begin
                            tok_v      = 1'b1;
                            tok_type_v = ltl_pkg::TOK_ERROR;
                            tok_err_v  = ltl_pkg::ERR_EOF_STR;
                            st_v       = S_IDLE;
                        end
                        else if (c_v == ltl_pkg::CH_DQUOTE)
                        begin
                            tok_v      = 1'b1;
                            tok_type_v = ltl_pkg::TOK_SYMBOL;
                            st_v       = S_IDLE;
                        end
                        else if (c_v == ltl_pkg::CH_BSLASH)
                        begin
                            st_v = S_DQ_BS;
                        end
                        else if (c_v == ltl_pkg::CH_LF)
                        begin
                            tok_v      = 1'b1;
                            tok_type_v = ltl_pkg::TOK_ERROR;
                            tok_err_v  = ltl_pkg::ERR_NL_STR;
                            st_v       = S_IDLE;
                        end
                        else
                        begin
                            take_v = 1'b1;
                        end
                    end
                    S_DQ_BS:
                    begin
                        if (eof_v)
                        begin
                            tok_v      = 1'b1;
                            tok_type_v = ltl_pkg::TOK_ERROR;
                            tok_err_v  = ltl_pkg::ERR_EOF_STR;
                            st_v       = S_IDLE;
                        end
                        else
                        begin
                            take_v = 1'b1;
                            st_v   = S_DQ;
                        end
                    end
                    S_CMT1:
                    begin
                        if (!eof_v && c_v == ltl_pkg::CH_SLASH)
                        begin
                            st_v = S_CMT2;
                        end
                        else if (!eof_v && c_v == ltl_pkg::CH_STAR)
                        begin
                            st_v = S_CMT3;
                        end
                        else
                        begin
                            tok_v      = 1'b1;
                            tok_type_v = ltl_pkg::TOK_DIV;
                            st_v       = S_IDLE;
                            go_v       = 1'b1;
                        end
                    end
                    S_CMT2:
                    begin
                        if (eof_v)
                        begin
                            tok_v      = 1'b1;
                            tok_type_v = ltl_pkg::TOK_END;
                            st_v       = S_IDLE;
                        end
                        else if (c_v == ltl_pkg::CH_LF)
                        begin
                            st_v = S_IDLE;
                        end
                    end
                    S_CMT3:
                    begin
                        if (eof_v)
                        begin
                            tok_v      = 1'b1;
                            tok_type_v = ltl_pkg::TOK_ERROR;
                            tok_err_v  = ltl_pkg::ERR_EOF_CMT;
                            st_v       = S_IDLE;
                        end
                        else if (c_v == ltl_pkg::CH_STAR)
                        begin
                            st_v = S_CMT4;
                        end
                    end
                    S_CMT4:
                    begin
                        if (eof_v)
                        begin
                            tok_v      = 1'b1;
                            tok_type_v = ltl_pkg::TOK_ERROR;
                            tok_err_v  = ltl_pkg::ERR_EOF_CMT;
                            st_v       = S_IDLE;
                        end
                        else if (c_v == ltl_pkg::CH_SLASH)
                        begin
                            st_v = S_IDLE;
                        end
                        else if (c_v != ltl_pkg::CH_STAR)
                        begin
                            st_v = S_CMT3;
                        end
                    end
                    default:
                    begin
                        st_v = S_IDLE;
                        go_v = 1'b1;
                    end
                endcase

                // a minus sign before a digit keeps the older last column
                if (minus_v)
                begin
                    res_v[n_v[0]] = mk_text(ltl_pkg::CH_MINUS, line_next, fc_v, lc_v);
                    n_v           = n_v + 2'd1;
                end
                if (take_v)
                begin
                    lc_v          = col_next;
                    res_v[n_v[0]] = mk_text(c_v, line_next, fc_v, lc_v);
                    n_v           = n_v + 2'd1;
                end
                if (tok_v)
                begin
                    res_v[n_v[0]] = mk_tok(tok_type_v, tok_err_v, line_next, fc_v, lc_v);
                    n_v           = n_v + 2'd1;
                end
            end
        end

        if (n_v == 2'd1)
        begin
            res_v[0].last = 1'b1;
        end
        else if (n_v == 2'd2)
        begin
            res_v[1].last = 1'b1;
        end

        state_next      = st_v;
        first_next      = fc_v;
        last_next       = lc_v;
        step_out.count  = n_v;
        step_out.res[0] = res_v[0];
        step_out.res[1] = res_v[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cr_reg    <= 1'b0;
            pnl_reg   <= 1'b0;
            line_reg  <= POSITION_BITS'(1);
            col_reg   <= '0;
            first_reg <= '0;
            last_reg  <= '0;
        end
        else if (step_valid)
        begin
            state_reg <= state_next;
            cr_reg    <= cr_next;
            pnl_reg   <= pnl_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            first_reg <= first_next;
            last_reg  <= last_next;
        end
    end

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg != '0)
        else $error("line counter left its legal range");

    a_crlf_silent: assert property (@(posedge clk) disable iff (!rst_n)
        step_valid && !item.end_of_file && item.char_in == ltl_pkg::CH_LF && cr_reg
        |-> step_out.count == 2'd0)
        else $error("lf after cr produced a result");

    a_eof_token: assert property (@(posedge clk) disable iff (!rst_n)
        step_valid && item.end_of_file
        |-> (step_out.count == 2'd1 && step_out.res[0].is_token) ||
            (step_out.count == 2'd2 && step_out.res[1].is_token))
        else $error("end of file did not close with a token");

    a_eof_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step_valid && item.end_of_file |=> state_reg == S_IDLE)
        else $error("lexer not idle after end of file");

endmodule

`default_nettype wire

// ===== hw/rtl/ltl_res_fifo.sv =====
`default_nettype none

module ltl_res_fifo (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push_en,
    input  wire ltl_pkg::step_out_t  push,
    input  wire logic                pop,
    output ltl_pkg::result_t         head,
    output logic                     not_empty,
    output logic                     room
);

    localparam int CNT_BITS = ltl_pkg::FIFO_PTR_BITS + 1;

    ltl_pkg::result_t                   mem [ltl_pkg::FIFO_DEPTH];
    logic [ltl_pkg::FIFO_PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next, wr_ptr_plus1;
    logic [ltl_pkg::FIFO_PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]                count_reg, count_next;
    logic [1:0]                         push_cnt;

    assign push_cnt     = push_en ? push.count : 2'd0;
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;
    assign wr_ptr_next  = wr_ptr_reg + ltl_pkg::FIFO_PTR_BITS'(push_cnt);
    assign rd_ptr_next  = rd_ptr_reg + ltl_pkg::FIFO_PTR_BITS'(pop);
    assign count_next   = count_reg + CNT_BITS'(push_cnt) - CNT_BITS'(pop);

    assign head      = mem[rd_ptr_reg];
    assign not_empty = count_reg != '0;
    // space for a two-result byte regardless of the drain side
    assign room      = count_reg <= CNT_BITS'(ltl_pkg::FIFO_DEPTH - 2);

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.res[0];
        end
        if (push_cnt == 2'd2)
        begin
            mem[wr_ptr_plus1] <= push.res[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, count_reg} + (CNT_BITS + 1)'(push_cnt)) <=
        ((CNT_BITS + 1)'(ltl_pkg::FIFO_DEPTH) + (CNT_BITS + 1)'(pop)))
        else $error("result queue overflow");

endmodule

`default_nettype wire

// ===== verif/liberty_text_lexer_tb.sv =====
module liberty_text_lexer_tb;

    localparam int REPORT_LIMIT   = 40;     // mismatch lines printed before going quiet
    localparam int WATCHDOG_LIMIT = 500;    // cycles with no transaction on either side
    localparam int HOLD_CYCLES    = 48;     // long receiver hold-off, fills the result queue
    localparam int RANDOM_ITEMS   = 36;
    localparam int HOLD_AFTER     = 12;     // random bytes sent before the long hold-off
    localparam int TAIL_CYCLES    = 8;

    // lexer states of the predictor
    typedef enum logic [3:0] {
        LX_IDLE, LX_IDLE_BS, LX_MINUS, LX_INT, LX_DOT, LX_FRAC, LX_EXP_SIGN, LX_EXP,
        LX_SYM, LX_QUOTE, LX_QUOTE_BS, LX_SLASH, LX_LINE_CMT, LX_BLOCK_CMT, LX_BLOCK_STAR
    } lex_state_t;

    // predicts the token stream byte by byte and checks results in order
    class lex_scoreboard;
        ltl_pkg::result_t pending_q[$];
        int               fail_count;
        lex_state_t       state;
        bit               cr_seen;
        bit               prev_nl;
        logic [15:0]      line_no;
        logic [15:0]      col_no;
        logic [15:0]      tok_first;
        logic [15:0]      tok_last;

        function new();
            fail_count = 0;
            state      = LX_IDLE;
            cr_seen    = 1'b0;
            prev_nl    = 1'b0;
            line_no    = 16'd1;
            col_no     = 16'd0;
            tok_first  = 16'd0;
            tok_last   = 16'd0;
        endfunction

        function void push(bit is_tok, logic [7:0] ch, ltl_pkg::token_t tok,
                           ltl_pkg::err_t err);
            ltl_pkg::result_t r;
            r.is_token     = is_tok;
            r.text_char    = ch;
            r.token_type   = tok;
            r.error_kind   = err;
            r.line_number  = line_no;
            r.first_column = tok_first;
            r.last_column  = tok_last;
            r.last         = 1'b0;
            pending_q.push_back(r);
        endfunction

        function void take(logic [7:0] ch);
            tok_last = col_no;
            push(1'b0, ch, ltl_pkg::TOK_END, ltl_pkg::ERR_NONE);
        endfunction

        function void finish(ltl_pkg::token_t tok);
            push(1'b1, 8'h00, tok, ltl_pkg::ERR_NONE);
            state = LX_IDLE;
        endfunction

        function void fail(ltl_pkg::err_t err);
            push(1'b1, 8'h00, ltl_pkg::TOK_ERROR, err);
            state = LX_IDLE;
        endfunction

        function void note_byte(ltl_pkg::item_t it);
            logic [7:0]       c;
            bit               eof;
            bit               dig;
            bit               alpha;
            bit               symch;
            bit               redo;
            int               base;
            ltl_pkg::result_t r;
            eof  = it.end_of_file;
            c    = eof ? 8'h00 : it.char_in;
            base = pending_q.size();
            if (!eof) begin
                if (c == ltl_pkg::CH_CR) begin
                    cr_seen = 1'b1;
                    c       = ltl_pkg::CH_LF;
                end
                else if (c == ltl_pkg::CH_LF && cr_seen) begin
                    cr_seen = 1'b0;
                    return;
                end
                else
                    cr_seen = 1'b0;
            end
            if (prev_nl) begin
                if (line_no != 16'hFFFF)
                    line_no++;
                col_no = 16'd1;
            end
            else if (col_no != 16'hFFFF)
                col_no++;
            prev_nl = !eof && c == ltl_pkg::CH_LF;

            dig   = !eof && c >= ltl_pkg::CH_0 && c <= ltl_pkg::CH_9;
            alpha = !eof && ((c >= ltl_pkg::CH_A_LO && c <= ltl_pkg::CH_Z_LO) ||
                             (c >= ltl_pkg::CH_A_UP && c <= ltl_pkg::CH_Z_UP));
            symch = alpha || (!eof && c == ltl_pkg::CH_UNDER)
                    || (it.sym_digits && (dig || (!eof && c == ltl_pkg::CH_DOT)));

            do begin
                redo = 1'b0;
                case (state)
                    LX_IDLE: begin
                        tok_first = col_no;
                        if (eof)
                            finish(ltl_pkg::TOK_END);
                        else if (symch) begin
                            take(c);
                            state = LX_SYM;
                        end
                        else if (dig) begin
                            take(c);
                            state = LX_INT;
                        end
                        else begin
                            case (c)
                                ltl_pkg::CH_DOT: begin
                                    take(c);
                                    state = LX_DOT;
                                end
                                ltl_pkg::CH_SPACE, ltl_pkg::CH_TAB: ;
                                ltl_pkg::CH_LF:     finish(ltl_pkg::TOK_NL);
                                ltl_pkg::CH_DQUOTE: state = LX_QUOTE;
                                ltl_pkg::CH_BSLASH: state = LX_IDLE_BS;
                                ltl_pkg::CH_SLASH:  state = LX_SLASH;
                                ltl_pkg::CH_COLON:  finish(ltl_pkg::TOK_COLON);
                                ltl_pkg::CH_SEMI:   finish(ltl_pkg::TOK_SEMI);
                                ltl_pkg::CH_COMMA:  finish(ltl_pkg::TOK_COMMA);
                                ltl_pkg::CH_PLUS:   finish(ltl_pkg::TOK_PLUS);
                                ltl_pkg::CH_MINUS:  state = LX_MINUS;
                                ltl_pkg::CH_STAR:   finish(ltl_pkg::TOK_MULT);
                                ltl_pkg::CH_LPAREN: finish(ltl_pkg::TOK_LPAREN);
                                ltl_pkg::CH_RPAREN: finish(ltl_pkg::TOK_RPAREN);
                                ltl_pkg::CH_LBRACE: finish(ltl_pkg::TOK_LBRACE);
                                ltl_pkg::CH_RBRACE: finish(ltl_pkg::TOK_RBRACE);
                                default:            fail(ltl_pkg::ERR_ILLEGAL);
                            endcase
                        end
                    end
                    LX_IDLE_BS: begin
                        state = LX_IDLE;
                        if (eof || c != ltl_pkg::CH_LF)
                            redo = 1'b1;
                    end
                    LX_MINUS: begin
                        if (dig) begin
                            push(1'b0, ltl_pkg::CH_MINUS, ltl_pkg::TOK_END, ltl_pkg::ERR_NONE);
                            take(c);
                            state = LX_INT;
                        end
                        else begin
                            finish(ltl_pkg::TOK_MINUS);
                            redo = 1'b1;
                        end
                    end
                    LX_INT: begin
                        if (dig)
                            take(c);
                        else if (!eof && c == ltl_pkg::CH_DOT) begin
                            take(c);
                            state = LX_DOT;
                        end
                        else begin
                            finish(ltl_pkg::TOK_INT);
                            redo = 1'b1;
                        end
                    end
                    LX_DOT: begin
                        if (dig) begin
                            take(c);
                            state = LX_FRAC;
                        end
                        else
                            fail(ltl_pkg::ERR_NO_DIGIT);
                    end
                    LX_FRAC: begin
                        if (dig)
                            take(c);
                        else if (!eof && (c == ltl_pkg::CH_E_LO || c == ltl_pkg::CH_E_UP)) begin
                            take(c);
                            state = LX_EXP_SIGN;
                        end
                        else begin
                            finish(ltl_pkg::TOK_FLOAT);
                            redo = 1'b1;
                        end
                    end
                    LX_EXP_SIGN: begin
                        if (dig || (!eof && (c == ltl_pkg::CH_PLUS ||
                                             c == ltl_pkg::CH_MINUS))) begin
                            take(c);
                            state = LX_EXP;
                        end
                        else
                            fail(ltl_pkg::ERR_NO_EXP);
                    end
                    LX_EXP: begin
                        if (dig)
                            take(c);
                        else begin
                            finish(ltl_pkg::TOK_FLOAT);
                            redo = 1'b1;
                        end
                    end
                    LX_SYM: begin
                        if (symch || dig)
                            take(c);
                        else begin
                            finish(ltl_pkg::TOK_SYMBOL);
                            redo = 1'b1;
                        end
                    end
                    LX_QUOTE: begin
                        if (eof)
                            fail(ltl_pkg::ERR_EOF_STR);
                        else if (c == ltl_pkg::CH_DQUOTE)
                            finish(ltl_pkg::TOK_SYMBOL);
                        else if (c == ltl_pkg::CH_BSLASH)
                            state = LX_QUOTE_BS;
                        else if (c == ltl_pkg::CH_LF)
                            fail(ltl_pkg::ERR_NL_STR);
                        else
                            take(c);
                    end
                    LX_QUOTE_BS: begin
                        if (eof)
                            fail(ltl_pkg::ERR_EOF_STR);
                        else begin
                            take(c);
                            state = LX_QUOTE;
                        end
                    end
                    LX_SLASH: begin
                        if (!eof && c == ltl_pkg::CH_SLASH)
                            state = LX_LINE_CMT;
                        else if (!eof && c == ltl_pkg::CH_STAR)
                            state = LX_BLOCK_CMT;
                        else begin
                            finish(ltl_pkg::TOK_DIV);
                            redo = 1'b1;
                        end
                    end
                    LX_LINE_CMT: begin
                        if (eof)
                            finish(ltl_pkg::TOK_END);
                        else if (c == ltl_pkg::CH_LF)
                            state = LX_IDLE;
                    end
                    LX_BLOCK_CMT: begin
                        if (eof)
                            fail(ltl_pkg::ERR_EOF_CMT);
                        else if (c == ltl_pkg::CH_STAR)
                            state = LX_BLOCK_STAR;
                    end
                    LX_BLOCK_STAR: begin
                        if (eof)
                            fail(ltl_pkg::ERR_EOF_CMT);
                        else if (c == ltl_pkg::CH_SLASH)
                            state = LX_IDLE;
                        else if (c != ltl_pkg::CH_STAR)
                            state = LX_BLOCK_CMT;
                    end
                    default: begin
                        state = LX_IDLE;
                        redo  = 1'b1;
                    end
                endcase
            end while (redo);

            if (pending_q.size() > base) begin
                r      = pending_q.pop_back();
                r.last = 1'b1;
                pending_q.push_back(r);
            end
        endfunction

        function void report_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("%0t mismatch %s: expected 0x%0h, actual 0x%0h",
                             $time, name, want, got);
            end
        endfunction

        function void check_result(ltl_pkg::result_t got);
            ltl_pkg::result_t want;
            if (pending_q.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("%0t unexpected result: expected none, actual 0x%0h", $time, got);
                return;
            end
            want = pending_q.pop_front();
            report_field("is_token", 16'(want.is_token), 16'(got.is_token));
            report_field("text_char", 16'(want.text_char), 16'(got.text_char));
            report_field("token_type", 16'(want.token_type), 16'(got.token_type));
            report_field("error_kind", 16'(want.error_kind), 16'(got.error_kind));
            report_field("line_number", want.line_number, got.line_number);
            report_field("first_column", want.first_column, got.first_column);
            report_field("last_column", want.last_column, got.last_column);
            report_field("last", 16'(want.last), 16'(got.last));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ltl_in_if  char_if ();
    ltl_out_if lex_if ();

    liberty_text_lexer u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_stream (char_if),
        .lex_stream  (lex_if)
    );

    always #10 clk = ~clk;

    lex_scoreboard sb;
    int  sent_count = 0;
    int  burst_left = 0;
    bit  gapless    = 1'b0;   // sender offers back to back for the closing stretch
    bit  hold_req   = 1'b0;   // asks the receiver for its long hold-off
    bit  hold_done  = 1'b0;
    int  quiet_cycles = 0;

    // every input known from time zero
    initial begin
        char_if.valid       = 1'b0;
        char_if.char_in     = 8'h00;
        char_if.end_of_file = 1'b0;
        char_if.sym_digits  = 1'b0;
        lex_if.ready        = 1'b0;
    end

    // ---------------------------------------------------------------------------------------
    // sender side
    // ---------------------------------------------------------------------------------------

    // offer one byte transaction, hold it until taken, then maybe open a gap
    task automatic send_item(input ltl_pkg::item_t it);
        char_if.valid       <= 1'b1;
        char_if.char_in     <= it.char_in;
        char_if.end_of_file <= it.end_of_file;
        char_if.sym_digits  <= it.sym_digits;
        do
            @(posedge clk);
        while (!char_if.ready);
        // taken at this edge: predict what it produces
        sb.note_byte(it);
        sent_count++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0 && !gapless) begin
            char_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
    endtask

    task automatic send_char(input logic [7:0] c, input bit sym);
        ltl_pkg::item_t it;
        it.char_in     = c;
        it.end_of_file = 1'b0;
        it.sym_digits  = sym;
        send_item(it);
    endtask

    // char_in is don't-care on an end mark, so let it wander
    task automatic send_eof();
        ltl_pkg::item_t it;
        it.char_in     = 8'($urandom_range(0, 255));
        it.end_of_file = 1'b1;
        it.sym_digits  = 1'($urandom_range(0, 1));
        send_item(it);
    endtask

    task automatic send_text(input string s, input bit sym);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], sym);
    endtask

    function automatic logic [7:0] pick_letter();
        string letters;
        letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
        return letters[$urandom_range(0, letters.len() - 1)];
    endfunction

    function automatic logic [7:0] pick_digit();
        return ltl_pkg::CH_0 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_printable();
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    // one random piece of text: mostly well-formed tokens, some broken ones, some noise
    task automatic send_fragment();
        logic [7:0] c;
        string      punct;
        punct = ":;,+-*/(){}";
        case ($urandom_range(0, 11))
            0: begin
                // symbol; digits and dot join it when sym_digits is up
                send_char(pick_letter(), 1'b0);
                repeat ($urandom_range(0, 4)) begin
                    if ($urandom_range(0, 2) == 0)
                        send_char(pick_digit(), 1'($urandom_range(0, 1)));
                    else if ($urandom_range(0, 4) == 0)
                        send_char(ltl_pkg::CH_DOT, 1'b1);
                    else
                        send_char(pick_letter(), $urandom_range(0, 5) == 0);
                end
            end
            1: begin
                // integer, sometimes negative
                if ($urandom_range(0, 2) == 0)
                    send_char(ltl_pkg::CH_MINUS, 1'b0);
                repeat ($urandom_range(1, 4)) send_char(pick_digit(), 1'b0);
            end
            2: begin
                // float with optional exponent and sign
                repeat ($urandom_range(0, 3)) send_char(pick_digit(), 1'b0);
                send_char(ltl_pkg::CH_DOT, 1'b0);
                repeat ($urandom_range(1, 3)) send_char(pick_digit(), 1'b0);
                if ($urandom_range(0, 1) == 1) begin
                    send_char($urandom_range(0, 1) ? ltl_pkg::CH_E_LO : ltl_pkg::CH_E_UP, 1'b0);
                    case ($urandom_range(0, 2))
                        0: send_char(ltl_pkg::CH_PLUS, 1'b0);
                        1: send_char(ltl_pkg::CH_MINUS, 1'b0);
                        default: ;
                    endcase
                    repeat ($urandom_range(1, 2)) send_char(pick_digit(), 1'b0);
                end
            end
            3: begin
                // quoted string with escapes, including escaped quote and line breaks
                send_char(ltl_pkg::CH_DQUOTE, 1'b0);
                repeat ($urandom_range(0, 5)) begin
                    if ($urandom_range(0, 4) == 0) begin
                        send_char(ltl_pkg::CH_BSLASH, 1'b0);
                        case ($urandom_range(0, 3))
                            0: send_char(ltl_pkg::CH_DQUOTE, 1'b0);
                            1: send_char(ltl_pkg::CH_LF, 1'b0);
                            2: send_char(ltl_pkg::CH_CR, 1'b0);
                            default: send_char(pick_printable(), 1'b0);
                        endcase
                    end
                    else begin
                        c = pick_printable();
                        if (c == ltl_pkg::CH_DQUOTE || c == ltl_pkg::CH_BSLASH)
                            c = ltl_pkg::CH_A_LO;
                        send_char(c, 1'($urandom_range(0, 1)));
                    end
                end
                send_char(ltl_pkg::CH_DQUOTE, 1'b0);
            end
            4: send_char(punct[$urandom_range(0, punct.len() - 1)], 1'b0);
            5: begin
                // blanks and every line break flavor
                case ($urandom_range(0, 4))
                    0: send_char(ltl_pkg::CH_SPACE, 1'b0);
                    1: send_char(ltl_pkg::CH_TAB, 1'b0);
                    2: send_char(ltl_pkg::CH_CR, 1'b0);
                    3: send_char(ltl_pkg::CH_LF, 1'b0);
                    default: begin
                        send_char(ltl_pkg::CH_CR, 1'b0);
                        send_char(ltl_pkg::CH_LF, 1'b0);
                    end
                endcase
            end
            6: begin
                send_char(ltl_pkg::CH_SLASH, 1'b0);
                send_char(ltl_pkg::CH_SLASH, 1'b0);
                repeat ($urandom_range(0, 4)) send_char(pick_printable(), 1'b0);
                send_char($urandom_range(0, 1) ? ltl_pkg::CH_LF : ltl_pkg::CH_CR, 1'b0);
            end
            7: begin
                // block comment, stars weighted so runs of them show up
                send_char(ltl_pkg::CH_SLASH, 1'b0);
                send_char(ltl_pkg::CH_STAR, 1'b0);
                repeat ($urandom_range(0, 5)) begin
                    if ($urandom_range(0, 2) == 0)
                        send_char(ltl_pkg::CH_STAR, 1'b0);
                    else
                        send_char(pick_printable(), 1'b0);
                end
                send_char(ltl_pkg::CH_STAR, 1'b0);
                send_char(ltl_pkg::CH_SLASH, 1'b0);
            end
            8: begin
                // line continuation, or a stray backslash before a normal byte
                send_char(ltl_pkg::CH_BSLASH, 1'b0);
                case ($urandom_range(0, 2))
                    0: send_char(ltl_pkg::CH_LF, 1'b0);
                    1: send_char(ltl_pkg::CH_CR, 1'b0);
                    default: send_char(pick_letter(), 1'b0);
                endcase
            end
            9: begin
                // broken tokens
                case ($urandom_range(0, 3))
                    0: begin
                        send_char(ltl_pkg::CH_DOT, 1'b0);
                        send_char(pick_letter(), 1'b0);
                    end
                    1: begin
                        send_char(pick_digit(), 1'b0);
                        send_char(ltl_pkg::CH_DOT, 1'b0);
                        send_char(pick_digit(), 1'b0);
                        send_char(ltl_pkg::CH_E_LO, 1'b0);
                        send_char($urandom_range(0, 1) ? ltl_pkg::CH_SEMI : pick_letter(), 1'b0);
                    end
                    2: begin
                        send_char(ltl_pkg::CH_DQUOTE, 1'b0);
                        send_char(pick_letter(), 1'b0);
                        send_char(ltl_pkg::CH_LF, 1'b0);
                    end
                    default: begin
                        send_char(ltl_pkg::CH_MINUS, 1'b0);
                        send_char(pick_letter(), 1'b0);
                    end
                endcase
            end
            default: begin
                // raw noise over the whole byte range, end marks included
                if ($urandom_range(0, 5) == 0)
                    send_eof();
                else
                    send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
        endcase
    endtask

    // ---------------------------------------------------------------------------------------
    // receiver side: a stall pattern picked at random from four, plus one long hold-off
    // ---------------------------------------------------------------------------------------
    initial begin
        int cyc;
        int mode;
        cyc  = 0;
        mode = 0;
        wait (rst_n);
        forever begin
            @(posedge clk);
            cyc++;
            if (hold_req && !hold_done) begin
                // sender keeps offering, so the result queue fills and input backs up
                lex_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else begin
                if (cyc % 64 == 0)
                    mode = $urandom_range(0, 3);
                case (mode)
                    0: lex_if.ready <= 1'b1;
                    1: lex_if.ready <= ($urandom_range(0, 3) != 0);
                    2: lex_if.ready <= ((cyc % 5) >= 2);
                    default: lex_if.ready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    // result transaction check
    always @(posedge clk) begin
        ltl_pkg::result_t got;
        if (rst_n && lex_if.valid && lex_if.ready) begin
            got.is_token     = lex_if.is_token;
            got.text_char    = lex_if.text_char;
            got.token_type   = lex_if.token_type;
            got.error_kind   = lex_if.error_kind;
            got.line_number  = lex_if.line_number;
            got.first_column = lex_if.first_column;
            got.last_column  = lex_if.last_column;
            got.last         = lex_if.last;
            sb.check_result(got);
        end
    end

    // watchdog: nothing moving on either side for too long means a hang
    always @(posedge clk) begin
        if (!rst_n || (char_if.valid && char_if.ready) || (lex_if.valid && lex_if.ready))
            quiet_cycles <= 0;
        else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL liberty_text_lexer");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------------------------
    initial begin
        int rand_start;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        burst_left = $urandom_range(1, 16);

        // directed: every token type and error kind, byte extremes, the awkward corners
        // minus then digit, float with lower-case exponent, empty string, minus before plus
        send_text("-7:_Zz09 .5e-2;\"\"-+", 1'b0);
        // line continuation, stray backslash, escaped cr-lf inside quotes
        send_text("\\\n\\x\"\\\r\n\"", 1'b0);
        send_text("9.5E+1,", 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b0);
        // both comment styles, division, remaining punctuation
        send_text("//c\n/*a**/ /(){}*", 1'b0);
        // symbol mode folds digits and dot into a symbol
        send_text("1.x ", 1'b1);
        // no digit after dot, no exponent digit, newline in string, minus before cr
        send_text(".x 1.2E;\"\n-\r", 1'b0);
        send_text("\"a", 1'b0);
        send_eof();
        send_text("\"\\", 1'b0);
        send_eof();
        send_text("/*", 1'b0);
        send_eof();
        send_text("//", 1'b0);
        send_eof();
        send_text("\\", 1'b0);
        send_eof();
        send_text("/", 1'b0);
        send_eof();
        send_text("12", 1'b0);
        send_eof();
        send_eof();

        // random text, with the long receiver hold-off part way through
        rand_start = sent_count;
        while (sent_count - rand_start < RANDOM_ITEMS) begin
            if (sent_count - rand_start >= HOLD_AFTER)
                hold_req <= 1'b1;
            send_fragment();
        end

        // an end mark brings the lexer home, then a short gapless stretch
        send_eof();
        gapless = 1'b1;
        send_text("a b:", 1'b0);
        send_eof();
        gapless = 1'b0;
        char_if.valid <= 1'b0;

        // drain, then a short tail to catch stray results
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.fail_count == 0)
            $display("PASS liberty_text_lexer");
        else
            $display("FAIL liberty_text_lexer");
        $finish;
    end

endmodule
